>>> sv/esme_pkg.sv
// Shared types and constants for the ELLPACK sparse matrix engine.
// No dependencies.
package esme_pkg;

    localparam int VEC_DEPTH = 1024;
    localparam int VAL_W     = 32;
    localparam int COL_W     = 11;
    localparam int SLOT_W    = COL_W + VAL_W;
    localparam int TERM_W    = 48;

    localparam logic [COL_W-1:0] COL_EMPTY = 11'h7FF;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_ADD    = 3'd1;
    localparam logic [2:0] REQ_GET    = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_VWRITE = 3'd4;
    localparam logic [2:0] REQ_MUL    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RD,
        S_CHK,
        S_VWAIT,
        S_ACC,
        S_CLR_ROW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } t_mac_ctl;

endpackage

>>> sv/esme_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module esme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/esme_mac.sv
// Multiply, round to Q16.16, accumulate and saturate for row products.
// Depends on esme_pkg.
module esme_mac #(
    parameter int ACC_W = 52
) (
    input  logic                      i_clk,
    input  esme_pkg::t_mac_ctl        i_ctl,
    input  logic signed [31:0]        i_a,
    input  logic signed [31:0]        i_b,
    output logic signed [31:0]        o_sum
);
    import esme_pkg::*;

    logic signed [63:0]       r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [63:0]       rnd;
    logic [TERM_W-1:0]        term;
    logic                     hi_ones;
    logic                     hi_zero;

    assign rnd  = r_prod + 64'sd32768;
    assign term = rnd[63:16];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
        end
    end

    assign hi_ones = &r_acc[ACC_W-1:31];
    assign hi_zero = ~|r_acc[ACC_W-1:31];

    always_comb begin
        if (hi_ones || hi_zero) begin
            o_sum = r_acc[31:0];
        end else if (r_acc[ACC_W-1]) begin
            o_sum = 32'sh8000_0000;
        end else begin
            o_sum = 32'sh7FFF_FFFF;
        end
    end
endmodule

>>> sv/ellpack_sparse_matrix_engine.sv
// Top level of the ELLPACK sparse matrix engine: request sequencer.
// Depends on esme_pkg, esme_ram and esme_mac.
//
// Usage:
//   Requests enter on i_in_valid/o_in_ready; one result beat per request
//   leaves on o_out_valid/i_out_ready with o_status and o_value_out.
//   rows_in_use is written through i_rows_in_use_we/i_rows_in_use.
//   One request is worked at a time. Each slot visited passes through
//   slot memory read and check for insert, add and get; through slot
//   read, check, vector read and accumulate for a row product; and
//   through a slot write alone for a row clear. Vector writes and
//   rejected requests go from idle straight to the done state. The
//   single-port-read slot memory sets the pace. After reset a clearing
//   pass writes every slot empty and every vector element zero. No
//   request is taken during it; config writes are. A finished result
//   waits in the output register while the next request is accepted;
//   when the receiver stalls with a result waiting and another
//   finished, the sequencer holds until the output register frees.
module ellpack_sparse_matrix_engine #(
    parameter int MAX_ROWS      = 1024,
    parameter int SLOTS_PER_ROW = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [9:0]  i_row,
    input  logic [9:0]  i_col,
    input  logic signed [31:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic signed [31:0] o_value_out,
    input  logic        i_rows_in_use_we,
    input  logic [10:0] i_rows_in_use
);
    import esme_pkg::*;

    localparam int SDEPTH = MAX_ROWS * SLOTS_PER_ROW;
    localparam int AW     = $clog2(SDEPTH);
    localparam int VAW    = $clog2(VEC_DEPTH);
    localparam int CLR_N  = (SDEPTH > VEC_DEPTH) ? SDEPTH : VEC_DEPTH;
    localparam int CLW    = $clog2(CLR_N);
    localparam int JW     = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
    localparam int ACC_W  = TERM_W + $clog2(SLOTS_PER_ROW) + 1;
    localparam logic [JW-1:0]  J_LAST  = JW'(SLOTS_PER_ROW - 1);
    localparam logic [CLW-1:0] CLR_END = CLW'(CLR_N - 1);

    t_state r_state, n_state;
    logic [CLW-1:0]    r_clr, n_clr;
    logic [JW-1:0]     r_j, n_j;
    logic [AW-1:0]     r_base, n_base;
    logic [2:0]        r_req, n_req;
    logic [COL_W-1:0]  r_col, n_col;
    logic [31:0]       r_val, n_val;
    logic [31:0]       r_sval, n_sval;
    logic [1:0]        r_st, n_st;
    logic [31:0]       r_res, n_res;
    logic [VAW-1:0]    r_vaddr, n_vaddr;
    logic [10:0]       r_rows;
    logic              r_out_valid;
    logic [1:0]        r_out_st;
    logic [31:0]       r_out_val;

    logic              s_we;
    logic [AW-1:0]     s_waddr;
    logic [SLOT_W-1:0] s_wdata;
    logic [SLOT_W-1:0] s_rdata;
    logic              v_we;
    logic [VAW-1:0]    v_waddr;
    logic [31:0]       v_wdata;
    logic [31:0]       v_rdata;
    t_mac_ctl          mac_ctl;
    logic signed [31:0] mac_sum;

    logic [31:0]       limit;
    logic [COL_W-1:0]  c_col;
    logic [31:0]       c_val;
    logic [32:0]       add_sum;
    logic [31:0]       add_sat;
    logic              hit;
    logic              out_load;

    esme_ram #(.WIDTH(SLOT_W), .DEPTH(SDEPTH)) u_slots (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(r_base + AW'(r_j)), .o_rdata(s_rdata)
    );

    esme_ram #(.WIDTH(32), .DEPTH(VEC_DEPTH)) u_vec (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(n_vaddr), .o_rdata(v_rdata)
    );

    esme_mac #(.ACC_W(ACC_W)) u_mac (
        .i_clk(i_clk), .i_ctl(mac_ctl), .i_a(r_sval), .i_b(v_rdata), .o_sum(mac_sum)
    );

    assign limit   = (32'(r_rows) > MAX_ROWS) ? 32'(MAX_ROWS) : 32'(r_rows);
    assign c_col   = s_rdata[SLOT_W-1:VAL_W];
    assign c_val   = s_rdata[VAL_W-1:0];
    assign hit     = (c_col == r_col) || (c_col == COL_EMPTY);
    assign add_sum = {(c_col == COL_EMPTY) ? 1'b0 : c_val[31],
                      (c_col == COL_EMPTY) ? 32'd0 : c_val}
                     + {r_val[31], r_val};
    assign add_sat = (add_sum[32] == add_sum[31]) ? add_sum[31:0]
                   : (add_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign out_load = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr       <= '0;
            r_rows      <= 11'd1024;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_rows_in_use_we) begin
                r_rows <= i_rows_in_use;
            end
            if (r_state == S_DONE && out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_j     <= n_j;
        r_base  <= n_base;
        r_req   <= n_req;
        r_col   <= n_col;
        r_val   <= n_val;
        r_sval  <= n_sval;
        r_st    <= n_st;
        r_res   <= n_res;
        r_vaddr <= n_vaddr;
        if (r_state == S_DONE && out_load) begin
            r_out_st  <= r_st;
            r_out_val <= (r_req == REQ_MUL && r_st == ST_OK) ? mac_sum : r_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_j     = r_j;
        n_base  = r_base;
        n_req   = r_req;
        n_col   = r_col;
        n_val   = r_val;
        n_sval  = r_sval;
        n_st    = r_st;
        n_res   = r_res;
        n_vaddr = r_vaddr;
        s_we    = 1'b0;
        s_waddr = r_base + AW'(r_j);
        s_wdata = {COL_EMPTY, 32'd0};
        v_we    = 1'b0;
        v_waddr = r_col[VAW-1:0];
        v_wdata = r_val;
        mac_ctl = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_INIT: begin
                s_we    = (32'(r_clr) < SDEPTH);
                s_waddr = r_clr[AW-1:0];
                v_we    = (32'(r_clr) < VEC_DEPTH);
                v_waddr = r_clr[VAW-1:0];
                v_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == CLR_END) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                mac_ctl.clear = 1'b1;
                if (i_in_valid) begin
                    n_req  = i_req_type;
                    n_col  = {1'b0, i_col};
                    n_val  = i_value_in;
                    n_j    = '0;
                    n_base = AW'(32'(i_row) * SLOTS_PER_ROW);
                    n_st   = ST_OK;
                    n_res  = '0;
                    n_state = S_DONE;
                    if (i_req_type == REQ_VWRITE) begin
                        v_we    = 1'b1;
                        v_waddr = i_col[VAW-1:0];
                        v_wdata = i_value_in;
                    end else if (i_req_type <= REQ_MUL) begin
                        if (32'(i_row) >= limit) begin
                            n_st = ST_RANGE;
                        end else if (i_req_type == REQ_CLEAR) begin
                            n_state = S_CLR_ROW;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_sval  = c_val;
                n_vaddr = c_col[VAW-1:0];
                if (r_req == REQ_MUL) begin
                    n_state = (c_col == COL_EMPTY) ? S_DONE : S_VWAIT;
                end else if (r_req == REQ_GET) begin
                    if (c_col == r_col) begin
                        n_res   = c_val;
                        n_state = S_DONE;
                    end else if (c_col == COL_EMPTY || r_j == J_LAST) begin
                        n_st    = ST_MISSING;
                        n_state = S_DONE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    if (hit) begin
                        s_we    = 1'b1;
                        s_wdata = {r_col, (r_req == REQ_ADD) ? add_sat : r_val};
                        n_state = S_DONE;
                    end else if (r_j == J_LAST) begin
                        n_st    = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_VWAIT: begin
                mac_ctl.mul_en = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                mac_ctl.acc_en = 1'b1;
                if (r_j == J_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_RD;
                end
            end
            S_CLR_ROW: begin
                s_we = 1'b1;
                if (r_j == J_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_value_out = r_out_val;

    a_no_out_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_out_valid)
        else $error("result during clearing pass");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result not from done state");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_value_out == 0))
        else $error("failed request carries a value");
    a_no_slot_write_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT && r_req == REQ_MUL && r_state != S_IDLE) |-> !s_we)
        else $error("slot write during row product");
endmodule

>>> tb/tb_ellpack_sparse_matrix_engine.sv
// Testbench for ellpack_sparse_matrix_engine: directed and random requests, row-limit
// changes, with random valid/ready gaps and a scoreboard of predicted results.
// Depends on esme_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb_ellpack_sparse_matrix_engine;
    import esme_pkg::*;

    localparam int NROWS = 1024;
    localparam int NSLOTS = 8;
    localparam int WDOG_LIMIT = 40000;

    typedef struct packed {
        logic [2:0]  req;
        logic [9:0]  row;
        logic [9:0]  col;
        logic [31:0] val;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_ready;
    logic [2:0]  req_type;
    logic [9:0]  row;
    logic [9:0]  col;
    logic [31:0] value_in;
    logic        o_out_valid;
    logic        out_ready;
    logic [1:0]  o_status;
    logic signed [31:0] o_value_out;
    logic        rows_we;
    logic [10:0] rows_data;

    ellpack_sparse_matrix_engine i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_ready(o_in_ready),
        .i_req_type(req_type),
        .i_row(row),
        .i_col(col),
        .i_value_in(value_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_status(o_status),
        .o_value_out(o_value_out),
        .i_rows_in_use_we(rows_we),
        .i_rows_in_use(rows_data)
    );

    // matrix image
    logic [10:0] m_col[NROWS*NSLOTS];
    logic [31:0] m_val[NROWS*NSLOTS];
    logic [31:0] m_vec[VEC_DEPTH];
    logic [10:0] m_rows;

    t_req  pend_q[$];
    t_resp resp_q[$];
    t_req  cur;
    int    send_gap;
    int    recv_stall;
    int    hold_cnt;
    int    hold_req;
    int    hold_seen;
    bit    no_idle;
    int    errors;
    int    n_sent;
    int    n_recv;
    int    n_queued;
    int    st_count[4];
    int    wdog;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_resp apply_request(input t_req r);
        t_resp res;
        int base;
        int j;
        int hit;
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        logic signed [63:0] old;
        res.status = ST_OK;
        res.value = '0;
        if (r.req > REQ_MUL) return res;
        if (r.req == REQ_VWRITE) begin
            m_vec[r.col] = r.val;
            return res;
        end
        if ({1'b0, r.row} >= ((m_rows > NROWS) ? NROWS : m_rows)) begin
            res.status = ST_RANGE;
            return res;
        end
        base = r.row * NSLOTS;
        hit = NSLOTS;
        for (j = NSLOTS - 1; j >= 0; j--)
            if (m_col[base+j] == COL_EMPTY || m_col[base+j] == {1'b0, r.col}) hit = j;
        case (r.req)
            REQ_INSERT, REQ_ADD: begin
                if (hit == NSLOTS) begin
                    res.status = ST_FULL;
                end else begin
                    if (r.req == REQ_INSERT) begin
                        m_val[base+hit] = r.val;
                    end else begin
                        old = (m_col[base+hit] == COL_EMPTY) ? 64'sd0
                              : 64'($signed(m_val[base+hit]));
                        m_val[base+hit] = sat32(old + 64'($signed(r.val)));
                    end
                    m_col[base+hit] = {1'b0, r.col};
                end
            end
            REQ_GET: begin
                if (hit < NSLOTS && m_col[base+hit] == {1'b0, r.col})
                    res.value = m_val[base+hit];
                else
                    res.status = ST_MISSING;
            end
            REQ_CLEAR: begin
                for (j = 0; j < NSLOTS; j++) begin
                    m_col[base+j] = COL_EMPTY;
                    m_val[base+j] = '0;
                end
            end
            default: begin
                acc = 0;
                for (j = 0; j < NSLOTS; j++) begin
                    if (m_col[base+j] == COL_EMPTY) break;
                    prod = 64'($signed(m_val[base+j])) *
                           64'($signed(m_vec[m_col[base+j][9:0]]));
                    acc += (prod + 64'sd32768) >>> 16;
                end
                res.value = sat32(acc);
            end
        endcase
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sender
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            nv = in_valid;
            if (in_valid && o_in_ready) begin
                resp_q.push_back(apply_request(cur));
                n_sent++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (pend_q.size() > 0) begin
                    cur = pend_q.pop_front();
                    req_type <= cur.req;
                    row <= cur.row;
                    col <= cur.col;
                    value_in <= cur.val;
                    nv = 1'b1;
                    send_gap <= no_idle ? 0 : $urandom_range(0, 16);
                end
            end
            in_valid <= nv;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        logic  nr;
        t_resp want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_stall <= 0;
            hold_cnt = 0;
            hold_seen = 0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_cnt = 400;
            end
            nr = out_ready;
            if (o_out_valid && out_ready) begin
                n_recv++;
                st_count[o_status]++;
                if (resp_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat: status %0d value %h",
                                               o_status, o_value_out);
                end else begin
                    want = resp_q.pop_front();
                    if (want.status !== o_status || want.value !== o_value_out) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at beat %0d: exp status %0d value %h, got %0d %h",
                                     n_recv, want.status, want.value, o_status, o_value_out);
                    end
                end
                nr = 1'b0;
                recv_stall <= no_idle ? 0 : $urandom_range(0, 16);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                nr = 1'b0;
            end else if (!nr && !(o_out_valid && out_ready)) begin
                if (recv_stall > 0) recv_stall <= recv_stall - 1;
                else nr = 1'b1;
            end
            out_ready <= nr;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", WDOG_LIMIT);
                $display("tb_ellpack_sparse_matrix_engine: done, errors");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [2:0] rq, input int r, input int c,
                            input logic [31:0] v);
        t_req it;
        it.req = rq;
        it.row = r[9:0];
        it.col = c[9:0];
        it.val = v;
        pend_q.push_back(it);
        n_queued++;
    endtask

    task automatic wait_idle();
        while (n_recv != n_queued || resp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_rows(input logic [10:0] v);
        @(posedge i_clk);
        rows_we <= 1'b1;
        rows_data <= v;
        m_rows = v;
        @(posedge i_clk);
        rows_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic rand_phase(input int n);
        int k;
        int w;
        logic [2:0] rq;
        int r;
        int c;
        for (k = 0; k < n; k++) begin
            w = $urandom_range(0, 99);
            if (w < 28) rq = REQ_INSERT;
            else if (w < 46) rq = REQ_ADD;
            else if (w < 64) rq = REQ_GET;
            else if (w < 69) rq = REQ_CLEAR;
            else if (w < 82) rq = REQ_VWRITE;
            else if (w < 97) rq = REQ_MUL;
            else rq = $urandom_range(6, 7);
            r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : $urandom_range(0, 1023);
            c = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 11) : $urandom_range(0, 1023);
            push_req(rq, r, c, rand_value());
        end
    endtask

    initial begin
        int k;
        int i;
        int limits[6];
        for (i = 0; i < NROWS*NSLOTS; i++) begin
            m_col[i] = COL_EMPTY;
            m_val[i] = '0;
        end
        for (i = 0; i < VEC_DEPTH; i++) m_vec[i] = '0;
        m_rows = 11'd1024;
        in_valid = 1'b0;
        out_ready = 1'b0;
        req_type = '0;
        row = '0;
        col = '0;
        value_in = '0;
        rows_we = 1'b0;
        rows_data = 11'd1024;
        hold_req = 0;
        no_idle = 1'b0;
        errors = 0;
        n_sent = 0;
        n_recv = 0;
        n_queued = 0;
        for (i = 0; i < 4; i++) st_count[i] = 0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_rows(11'd1024);

        // directed: extremes, overflow, full row, misses, vector, product
        push_req(REQ_GET, 0, 0, 0);
        push_req(REQ_INSERT, 0, 0, 32'h7FFF_FFFF);
        push_req(REQ_ADD, 0, 0, 32'h0001_0000);
        push_req(REQ_ADD, 1, 1023, 32'h8000_0000);
        push_req(REQ_ADD, 1, 1023, 32'hFFFF_0000);
        push_req(REQ_GET, 1, 1023, 0);
        for (k = 0; k < 9; k++) push_req(REQ_INSERT, 3, k * 100, 32'h0001_8000 + k);
        push_req(REQ_ADD, 3, 999, 32'h10);
        push_req(REQ_VWRITE, 777, 1023, 32'hFFFF_8000);
        push_req(REQ_VWRITE, 0, 0, 32'h7FFF_FFFF);
        push_req(REQ_INSERT, 1023, 0, 32'h7FFF_FFFF);
        push_req(REQ_MUL, 1023, 0, 0);
        push_req(REQ_MUL, 3, 0, 0);
        push_req(REQ_CLEAR, 3, 0, 0);
        push_req(REQ_GET, 3, 100, 0);
        push_req(3'd6, 5, 5, 32'h1234);
        push_req(3'd7, 1023, 1023, 32'hFFFF_FFFF);
        wait_idle();

        set_rows(11'd0);
        push_req(REQ_INSERT, 0, 5, 32'h1);
        push_req(REQ_VWRITE, 0, 5, 32'h2_0000);
        push_req(REQ_MUL, 0, 0, 0);
        wait_idle();

        limits[0] = 1; limits[1] = 5; limits[2] = 2047;
        limits[3] = 37; limits[4] = 1024; limits[5] = 6;
        for (i = 0; i < 7; i++) begin
            if (i < 6) set_rows(limits[i][10:0]);
            no_idle = (i == 2);
            if (i == 4) hold_req++;
            rand_phase(250);
            wait_idle();
        end

        repeat (50) @(posedge i_clk);
        $display("requests %0d, results %0d: ok %0d, full %0d, missing %0d, out of range %0d",
                 n_sent, n_recv, st_count[0], st_count[1], st_count[2], st_count[3]);
        $display("row limits 1024, 0, 1, 5, 2047, 37, 6 exercised; mismatches %0d", errors);
        if (errors == 0 && resp_q.size() == 0)
            $display("tb_ellpack_sparse_matrix_engine: done, clean");
        else
            $display("tb_ellpack_sparse_matrix_engine: done, errors");
        $finish;
    end

endmodule
